// ===== src/otq_pkg.sv =====
// shared types and constants for the ordered timer queue
package otq_pkg;

  localparam int EXP_W = 48;
  localparam int ID_W  = 32;
  localparam int DLY_W = 32;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_DEL   = 2'd1,
    ACT_CHECK = 2'd2,
    ACT_QUERY = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NOTHING   = 2'd2,
    ST_FULL      = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_DRAIN  = 2'd2,
    S_FINISH = 2'd3
  } state_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic commit;
  } otq_cmd_t;

  typedef struct packed {
    logic issue_last;
    logic out_free;
  } otq_sts_t;

endpackage

// ===== src/otq_if.sv =====
// valid/ready channel interfaces for requests and results
interface otq_in_if;
  import otq_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [EXP_W-1:0] now_ms;
  logic [DLY_W-1:0] delay_ms;
  logic [EXP_W-1:0] target_expiry;
  logic [ID_W-1:0]  target_id;

  modport source (output valid, action, now_ms, delay_ms, target_expiry, target_id,
                  input ready);
  modport sink   (input valid, action, now_ms, delay_ms, target_expiry, target_id,
                  output ready);
endinterface

interface otq_out_if;
  import otq_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [ID_W-1:0]  timer_id;
  logic [EXP_W-1:0] expiry_time;
  logic [EXP_W-1:0] sleep_ms;
  logic             queue_empty;

  modport source (output valid, status, timer_id, expiry_time, sleep_ms, queue_empty,
                  input ready);
  modport sink   (input valid, status, timer_id, expiry_time, sleep_ms, queue_empty,
                  output ready);
endinterface

// ===== src/otq_ctrl.sv =====
// sequencing state machine for one timer operation
module otq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  otq_pkg::otq_sts_t sts,
  output otq_pkg::otq_cmd_t cmd
);
  import otq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.issue_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
      end
      S_DRAIN: begin
      end
      S_FINISH: begin
        cmd.commit = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/otq_dp.sv =====
// timer table, scan pipeline, result register
module otq_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  otq_pkg::otq_cmd_t         cmd,
  output otq_pkg::otq_sts_t         sts,
  input  logic [1:0]                in_action,
  input  logic [otq_pkg::EXP_W-1:0] in_now_ms,
  input  logic [otq_pkg::DLY_W-1:0] in_delay_ms,
  input  logic [otq_pkg::EXP_W-1:0] in_target_expiry,
  input  logic [otq_pkg::ID_W-1:0]  in_target_id,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [otq_pkg::ID_W-1:0]  out_timer_id,
  output logic [otq_pkg::EXP_W-1:0] out_expiry_time,
  output logic [otq_pkg::EXP_W-1:0] out_sleep_ms,
  output logic                      out_queue_empty
);
  import otq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  logic [EXP_W-1:0] mem_exp [CAPACITY];
  logic [ID_W-1:0]  mem_id  [CAPACITY];
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [ID_W-1:0]  id_cnt_r, id_cnt_nxt;

  // request fields held for the whole operation
  act_t             act_r;
  logic [EXP_W-1:0] now_r;
  logic [DLY_W-1:0] delay_r;
  logic [EXP_W-1:0] texp_r;
  logic [ID_W-1:0]  tid_r;

  // scan pipeline: issue stage, then compare stage on registered read data
  logic [IW-1:0]    issue_idx_r;
  logic             s1_vld_r;
  logic [IW-1:0]    s1_idx_r;
  logic             s1_valid_r;
  logic [EXP_W-1:0] rd_exp_r;
  logic [ID_W-1:0]  rd_id_r;

  // scan result: free slot, match or minimum
  logic             hit_r;
  logic [IW-1:0]    hit_idx_r;
  logic [EXP_W-1:0] best_exp_r;
  logic [ID_W-1:0]  best_id_r;

  logic             out_valid_r;
  stat_t            status_r, status_nxt;
  logic [ID_W-1:0]  rid_r, rid_nxt;
  logic [EXP_W-1:0] rexp_r, rexp_nxt;
  logic [EXP_W-1:0] sleep_r, sleep_nxt;
  logic             empty_r;

  logic             take;
  logic             less;
  logic [EXP_W:0]   sum;
  logic [EXP_W-1:0] add_exp;
  logic             wr_en;

  assign sts.issue_last = cmd.issue && (issue_idx_r == LAST_IDX);
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act_r   <= act_t'(in_action);
      now_r   <= in_now_ms;
      delay_r <= in_delay_ms;
      texp_r  <= in_target_expiry;
      tid_r   <= in_target_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_idx_r <= '0;
      s1_vld_r    <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
      if (cmd.start) begin
        issue_idx_r <= '0;
      end else if (cmd.issue) begin
        issue_idx_r <= issue_idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r   <= issue_idx_r;
    s1_valid_r <= valid_r[issue_idx_r];
  end

  // single write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_exp[hit_idx_r] <= add_exp;
      mem_id[hit_idx_r]  <= id_cnt_nxt;
    end
    rd_exp_r <= mem_exp[issue_idx_r];
    rd_id_r  <= mem_id[issue_idx_r];
  end

  assign less = (rd_exp_r < best_exp_r) ||
                ((rd_exp_r == best_exp_r) && (rd_id_r < best_id_r));

  always_comb begin
    take = 1'b0;
    case (act_r)
      ACT_ADD:   take = !s1_valid_r && !hit_r;
      ACT_DEL:   take = s1_valid_r && !hit_r &&
                        (rd_exp_r == texp_r) && (rd_id_r == tid_r);
      ACT_CHECK,
      ACT_QUERY: take = s1_valid_r && (!hit_r || less);
      default:   take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.start) begin
      hit_r <= 1'b0;
    end else if (s1_vld_r && take) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && take) begin
      hit_idx_r  <= s1_idx_r;
      best_exp_r <= rd_exp_r;
      best_id_r  <= rd_id_r;
    end
  end

  // saturating expiry for add
  assign sum     = {1'b0, now_r} + {{(EXP_W + 1 - DLY_W){1'b0}}, delay_r};
  assign add_exp = sum[EXP_W] ? {EXP_W{1'b1}} : sum[EXP_W-1:0];

  always_comb begin
    valid_nxt  = valid_r;
    count_nxt  = count_r;
    id_cnt_nxt = id_cnt_r;
    status_nxt = ST_DONE;
    rid_nxt    = '0;
    rexp_nxt   = '0;
    sleep_nxt  = '0;
    wr_en      = 1'b0;
    case (act_r)
      ACT_ADD: begin
        if (hit_r) begin
          id_cnt_nxt           = id_cnt_r + ID_W'(1);
          valid_nxt[hit_idx_r] = 1'b1;
          count_nxt            = count_r + CW'(1);
          rid_nxt              = id_cnt_nxt;
          rexp_nxt             = add_exp;
          wr_en                = cmd.commit;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      ACT_DEL: begin
        if (hit_r) begin
          valid_nxt[hit_idx_r] = 1'b0;
          count_nxt            = count_r - CW'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      ACT_CHECK: begin
        if (hit_r && (best_exp_r <= now_r)) begin
          valid_nxt[hit_idx_r] = 1'b0;
          count_nxt            = count_r - CW'(1);
          rid_nxt              = best_id_r;
          rexp_nxt             = best_exp_r;
        end else begin
          status_nxt = ST_NOTHING;
        end
      end
      ACT_QUERY: begin
        if (!hit_r) begin
          status_nxt = ST_NOTHING;
        end else if (best_exp_r > now_r) begin
          sleep_nxt = best_exp_r - now_r;
        end
      end
      default: status_nxt = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      id_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        valid_r     <= valid_nxt;
        count_r     <= count_nxt;
        id_cnt_r    <= id_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_nxt;
      rid_r    <= rid_nxt;
      rexp_r   <= rexp_nxt;
      sleep_r  <= sleep_nxt;
      empty_r  <= (count_nxt == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_timer_id    = rid_r;
  assign out_expiry_time = rexp_r;
  assign out_sleep_ms    = sleep_r;
  assign out_queue_empty = empty_r;

endmodule

// ===== src/ordered_timer_queue_unit.sv =====
// Ordered timer queue: a table of CAPACITY pending timers kept in one entry
// memory with a single read port. Every request (add, delete, check-and-fire,
// query) walks the whole table one entry per cycle to find a free slot, the
// matching key or the earliest timer (smallest expiry, then smallest id). The
// result beat is registered at the commit, which follows the walk and the
// last compare. The next request is accepted in the cycle after the commit,
// so a new request is not taken before the last one is committed. A result
// beat that has not been taken delays the commit of the next one, while the
// next request is already being scanned.
module ordered_timer_queue_unit #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  otq_in_if.sink           in_ch,
  otq_out_if.source        out_ch
);
  import otq_pkg::*;

  otq_cmd_t cmd;
  otq_sts_t sts;

  otq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  otq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_ch.action),
    .in_now_ms        (in_ch.now_ms),
    .in_delay_ms      (in_ch.delay_ms),
    .in_target_expiry (in_ch.target_expiry),
    .in_target_id     (in_ch.target_id),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_timer_id     (out_ch.timer_id),
    .out_expiry_time  (out_ch.expiry_time),
    .out_sleep_ms     (out_ch.sleep_ms),
    .out_queue_empty  (out_ch.queue_empty)
  );

endmodule

// ===== bench/otq_result_checker.sv =====
// checker that predicts every timer queue result and compares it with the result channel
`timescale 1ns / 1ps
module otq_result_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  otq_in_if    in_ch,
  otq_out_if   out_ch,
  output int   mismatches,
  output int   pending,
  output int   results_seen,
  output int   timers_fired,
  output int   adds_refused
);
  import otq_pkg::*;

  typedef struct packed {
    stat_t            status;
    logic [ID_W-1:0]  timer_id;
    logic [EXP_W-1:0] expiry_time;
    logic [EXP_W-1:0] sleep_ms;
    logic             queue_empty;
  } timer_result_t;

  logic [EXP_W-1:0] slot_expiry [TABLE_DEPTH];
  logic [ID_W-1:0]  slot_ident  [TABLE_DEPTH];
  logic             slot_busy   [TABLE_DEPTH];
  logic [ID_W-1:0]  last_ident;
  timer_result_t    expected_results [$];

  // smallest expiry first, smaller id on a tie
  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_busy[i]) begin
        if (best < 0)
          best = i;
        else if (slot_expiry[i] < slot_expiry[best] ||
                 (slot_expiry[i] == slot_expiry[best] && slot_ident[i] < slot_ident[best]))
          best = i;
      end
    end
    return best;
  endfunction

  function automatic timer_result_t apply_timer_action(
    act_t             action,
    logic [EXP_W-1:0] now,
    logic [DLY_W-1:0] delay,
    logic [EXP_W-1:0] texp,
    logic [ID_W-1:0]  tid
  );
    timer_result_t  res;
    logic [EXP_W:0] sum;
    int             slot;
    res  = '0;
    slot = -1;
    case (action)
      ACT_ADD: begin
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
          if (!slot_busy[i]) slot = i;
        if (slot < 0) begin
          res.status = ST_FULL;
          adds_refused++;
        end else begin
          sum = now + delay;
          last_ident = last_ident + 1'b1;
          slot_expiry[slot] = sum[EXP_W] ? {EXP_W{1'b1}} : sum[EXP_W-1:0];
          slot_ident[slot]  = last_ident;
          slot_busy[slot]   = 1'b1;
          res.status      = ST_DONE;
          res.timer_id    = last_ident;
          res.expiry_time = slot_expiry[slot];
        end
      end
      ACT_DEL: begin
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
          if (slot_busy[i] && slot_expiry[i] == texp && slot_ident[i] == tid) slot = i;
        if (slot >= 0) begin
          slot_busy[slot] = 1'b0;
          res.status = ST_DONE;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      ACT_CHECK: begin
        slot = earliest_slot();
        if (slot >= 0 && slot_expiry[slot] <= now) begin
          res.status      = ST_DONE;
          res.timer_id    = slot_ident[slot];
          res.expiry_time = slot_expiry[slot];
          slot_busy[slot] = 1'b0;
          timers_fired++;
        end else begin
          res.status = ST_NOTHING;
        end
      end
      default: begin
        slot = earliest_slot();
        if (slot < 0)
          res.status = ST_NOTHING;
        else if (slot_expiry[slot] > now)
          res.sleep_ms = slot_expiry[slot] - now;
      end
    endcase
    res.queue_empty = (earliest_slot() < 0);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    timer_result_t want;
    if (!rst_n) begin
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      last_ident = '0;
      expected_results.delete();
      mismatches   = 0;
      results_seen = 0;
      timers_fired = 0;
      adds_refused = 0;
    end else begin
      // result beat first, so a beat can never match the request taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with nothing outstanding (status %0d id %0d)",
                     $time, out_ch.status, out_ch.timer_id);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status || out_ch.timer_id !== want.timer_id ||
              out_ch.expiry_time !== want.expiry_time || out_ch.sleep_ms !== want.sleep_ms ||
              out_ch.queue_empty !== want.queue_empty) begin
            if (mismatches < 10)
              $display("%0t: expected status %0d id %0d expiry %0d sleep %0d empty %0d",
                       $time, want.status, want.timer_id, want.expiry_time, want.sleep_ms,
                       want.queue_empty,
                       "\n    got      status %0d id %0d expiry %0d sleep %0d empty %0d",
                       out_ch.status, out_ch.timer_id, out_ch.expiry_time, out_ch.sleep_ms,
                       out_ch.queue_empty);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(apply_timer_action(act_t'(in_ch.action), in_ch.now_ms,
                                                      in_ch.delay_ms, in_ch.target_expiry,
                                                      in_ch.target_id));
    end
    pending = expected_results.size();
  end

endmodule

// ===== bench/tb_ordered_timer_queue_unit.sv =====
// top of the timer queue bench: clock, reset, request stimulus and the final verdict
`timescale 1ns / 1ps
module tb_ordered_timer_queue_unit;
  import otq_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam logic [EXP_W-1:0] MAX_EXP = {EXP_W{1'b1}};
  localparam logic [DLY_W-1:0] MAX_DLY = {DLY_W{1'b1}};

  logic clk;
  logic rst_n;

  otq_in_if  in_ch ();
  otq_out_if out_ch ();

  int mismatches;
  int pending;
  int results_seen;
  int timers_fired;
  int adds_refused;

  int send_idle_pct = 16;
  int recv_idle_pct = 79;
  int sent_by_action [4];

  logic [EXP_W-1:0]      wall_ms;
  logic [EXP_W+ID_W-1:0] known_keys [$];

  ordered_timer_queue_unit #(.CAPACITY(TABLE_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  otq_result_checker #(.TABLE_DEPTH(TABLE_DEPTH)) result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .timers_fired (timers_fired),
    .adds_refused (adds_refused)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // keys of added and fired timers, used as delete targets
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready && out_ch.timer_id != '0) begin
      known_keys.push_back({out_ch.expiry_time, out_ch.timer_id});
      if (known_keys.size() > 256) void'(known_keys.pop_front());
    end
  end

  task automatic send_req(act_t action, logic [EXP_W-1:0] now, logic [DLY_W-1:0] delay,
                          logic [EXP_W-1:0] texp, logic [ID_W-1:0] tid);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.action        = action;
    in_ch.now_ms        = now;
    in_ch.delay_ms      = delay;
    in_ch.target_expiry = texp;
    in_ch.target_id     = tid;
    in_ch.valid         = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sent_by_action[action]++;
  endtask

  task automatic idle_until_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_phase(int n_items);
    int                    done_items;
    int                    fill_at;
    int                    pick;
    act_t                  action;
    logic [EXP_W-1:0]      now_v;
    logic [EXP_W-1:0]      texp;
    logic [DLY_W-1:0]      dly;
    logic [ID_W-1:0]       tid;
    logic [EXP_W+ID_W-1:0] key;
    done_items = 0;
    fill_at    = $urandom_range(n_items / 2);
    while (done_items < n_items) begin
      if (done_items == fill_at) begin
        // run the table into full, then sweep it empty with a far-future now
        repeat (TABLE_DEPTH + 4) send_req(ACT_ADD, wall_ms, $urandom_range(500), '0, '0);
        repeat (TABLE_DEPTH + 4) send_req(ACT_CHECK, MAX_EXP, '0, '0, '0);
        done_items += 2 * TABLE_DEPTH + 8;
      end else begin
        pick    = $urandom_range(99);
        wall_ms = wall_ms + $urandom_range(8);
        now_v   = wall_ms;
        dly     = $urandom_range(400);
        texp    = '0;
        tid     = '0;
        if (pick < 10) begin
          action = act_t'($urandom_range(3));
          now_v  = EXP_W'({$urandom, $urandom});
          dly    = $urandom;
          texp   = EXP_W'({$urandom, $urandom});
          tid    = $urandom;
        end else if (pick < 45) begin
          action = ACT_ADD;
          if ($urandom_range(9) == 0) dly = $urandom;
        end else if (pick < 65) begin
          action = ACT_DEL;
          if (known_keys.size() > 0 && $urandom_range(4) != 0) begin
            key = known_keys[$urandom_range(known_keys.size() - 1)];
            {texp, tid} = key;
            // near miss on the id
            if ($urandom_range(7) == 0) tid = tid ^ 32'd1;
          end else begin
            texp = wall_ms + $urandom_range(400);
            tid  = $urandom_range(2000);
          end
        end else if (pick < 88) begin
          action = ACT_CHECK;
        end else begin
          action = ACT_QUERY;
        end
        send_req(action, now_v, dly, texp, tid);
        done_items++;
      end
    end
  endtask

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_ADD;
    in_ch.now_ms        = '0;
    in_ch.delay_ms      = '0;
    in_ch.target_expiry = '0;
    in_ch.target_id     = '0;
    out_ch.ready        = 1'b0;
    wall_ms             = '0;
    foreach (sent_by_action[i]) sent_by_action[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table, tie on expiry, delete hit and miss, saturated and boundary expiry
    send_req(ACT_QUERY, '0, '0, '0, '0);
    send_req(ACT_CHECK, '0, '0, '0, '0);
    send_req(ACT_DEL, '0, '0, '0, '0);
    send_req(ACT_ADD, '0, '0, '0, '0);
    send_req(ACT_ADD, 48'd100, 32'd50, '0, '0);
    send_req(ACT_ADD, '0, '0, '0, '0);
    send_req(ACT_QUERY, '0, '0, '0, '0);
    send_req(ACT_CHECK, '0, '0, '0, '0);
    send_req(ACT_CHECK, '0, '0, '0, '0);
    send_req(ACT_CHECK, 48'd10, '0, '0, '0);
    send_req(ACT_QUERY, 48'd10, '0, '0, '0);
    send_req(ACT_DEL, '0, '0, 48'd150, 32'd3);
    send_req(ACT_DEL, '0, '0, 48'd150, 32'd2);
    send_req(ACT_DEL, '0, '0, 48'd150, 32'd2);
    send_req(ACT_ADD, MAX_EXP, MAX_DLY, '0, '0);
    send_req(ACT_ADD, MAX_EXP - 5, 32'd5, '0, '0);
    send_req(ACT_ADD, MAX_EXP - 6, 32'd5, '0, '0);
    send_req(ACT_QUERY, '0, '0, '0, '0);
    send_req(ACT_CHECK, MAX_EXP - 1, '0, '0, '0);
    send_req(ACT_CHECK, MAX_EXP, '0, '0, '0);
    send_req(ACT_QUERY, MAX_EXP, '0, '0, '0);
    send_req(ACT_CHECK, MAX_EXP, '0, '0, '0);
    send_req(ACT_QUERY, MAX_EXP, MAX_DLY, MAX_EXP, {ID_W{1'b1}});
    idle_until_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 79 : 0;
      recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 16 : 0;
      run_phase(240);
      idle_until_drained();
    end

    repeat (2 * TABLE_DEPTH) @(negedge clk);
    $display("sent %0d requests: %0d add, %0d delete, %0d check, %0d query",
             sent_by_action[0] + sent_by_action[1] + sent_by_action[2] + sent_by_action[3],
             sent_by_action[ACT_ADD], sent_by_action[ACT_DEL], sent_by_action[ACT_CHECK],
             sent_by_action[ACT_QUERY]);
    $display("checked %0d results, %0d timers fired, %0d adds refused on a full table",
             results_seen, timers_fired, adds_refused);
    if (mismatches == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/otq_pkg.sv
src/otq_if.sv
src/otq_ctrl.sv
src/otq_dp.sv
src/ordered_timer_queue_unit.sv
bench/otq_result_checker.sv
bench/tb_ordered_timer_queue_unit.sv
